// ===== rtl/md5_pkg.sv =====
// Shared types, constants and round tables for the MD5 hash unit.
// No dependencies; md5_ctrl, md5_dp and md5_hash_unit refer to this package by scoped names.
`default_nettype none

package md5_pkg;

  // Initial chaining vector, word 0 in the low slot
  localparam logic [3:0][31:0] MD5_IV = {
    32'h10325476, 32'h98badcfe, 32'hefcdab89, 32'h67452301
  };

  // Padding marker appended after the last message byte
  localparam logic [7:0] PAD_BYTE = 8'h80;

  // Bit count added per message byte
  localparam logic [63:0] BITS_PER_BYTE = 64'd8;

  // Byte slot beyond which the length no longer fits in the current block
  localparam logic [5:0] LEN_LIMIT_POS = 6'd55;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic accept;   // input beat taken this cycle
    logic pad;      // append marker, clear tail, length if it fits
    logic len;      // clear low words and write length into the extra block
    logic load;     // copy chaining state into working words
    logic step;     // run one round
    logic add;      // fold working words into chaining state
    logic finish;   // hand digest to the output buffer and restart
  } md5_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic pos_last;    // next byte fills the block
    logic pos_gt55;    // length does not fit behind the marker
    logic round_last;  // round 63 in progress
    logic out_busy;    // digest buffer still holds words
  } md5_status_t;

  // Additive constant of a round
  function automatic logic [31:0] round_const(input logic [5:0] rc);
    logic [31:0] k;
    case (rc)
      6'd0:  k = 32'hd76aa478;  6'd1:  k = 32'he8c7b756;
      6'd2:  k = 32'h242070db;  6'd3:  k = 32'hc1bdceee;
      6'd4:  k = 32'hf57c0faf;  6'd5:  k = 32'h4787c62a;
      6'd6:  k = 32'ha8304613;  6'd7:  k = 32'hfd469501;
      6'd8:  k = 32'h698098d8;  6'd9:  k = 32'h8b44f7af;
      6'd10: k = 32'hffff5bb1;  6'd11: k = 32'h895cd7be;
      6'd12: k = 32'h6b901122;  6'd13: k = 32'hfd987193;
      6'd14: k = 32'ha679438e;  6'd15: k = 32'h49b40821;
      6'd16: k = 32'hf61e2562;  6'd17: k = 32'hc040b340;
      6'd18: k = 32'h265e5a51;  6'd19: k = 32'he9b6c7aa;
      6'd20: k = 32'hd62f105d;  6'd21: k = 32'h02441453;
      6'd22: k = 32'hd8a1e681;  6'd23: k = 32'he7d3fbc8;
      6'd24: k = 32'h21e1cde6;  6'd25: k = 32'hc33707d6;
      6'd26: k = 32'hf4d50d87;  6'd27: k = 32'h455a14ed;
      6'd28: k = 32'ha9e3e905;  6'd29: k = 32'hfcefa3f8;
      6'd30: k = 32'h676f02d9;  6'd31: k = 32'h8d2a4c8a;
      6'd32: k = 32'hfffa3942;  6'd33: k = 32'h8771f681;
      6'd34: k = 32'h6d9d6122;  6'd35: k = 32'hfde5380c;
      6'd36: k = 32'ha4beea44;  6'd37: k = 32'h4bdecfa9;
      6'd38: k = 32'hf6bb4b60;  6'd39: k = 32'hbebfbc70;
      6'd40: k = 32'h289b7ec6;  6'd41: k = 32'heaa127fa;
      6'd42: k = 32'hd4ef3085;  6'd43: k = 32'h04881d05;
      6'd44: k = 32'hd9d4d039;  6'd45: k = 32'he6db99e5;
      6'd46: k = 32'h1fa27cf8;  6'd47: k = 32'hc4ac5665;
      6'd48: k = 32'hf4292244;  6'd49: k = 32'h432aff97;
      6'd50: k = 32'hab9423a7;  6'd51: k = 32'hfc93a039;
      6'd52: k = 32'h655b59c3;  6'd53: k = 32'h8f0ccc92;
      6'd54: k = 32'hffeff47d;  6'd55: k = 32'h85845dd1;
      6'd56: k = 32'h6fa87e4f;  6'd57: k = 32'hfe2ce6e0;
      6'd58: k = 32'ha3014314;  6'd59: k = 32'h4e0811a1;
      6'd60: k = 32'hf7537e82;  6'd61: k = 32'hbd3af235;
      6'd62: k = 32'h2ad7d2bb;  6'd63: k = 32'heb86d391;
      default: k = 32'h0;
    endcase
    return k;
  endfunction

  // Left rotation amount of a round
  function automatic logic [4:0] rot_amount(input logic [5:0] rc);
    logic [4:0] r;
    case ({rc[5:4], rc[1:0]})
      4'h0: r = 5'd7;   4'h1: r = 5'd12;  4'h2: r = 5'd17;  4'h3: r = 5'd22;
      4'h4: r = 5'd5;   4'h5: r = 5'd9;   4'h6: r = 5'd14;  4'h7: r = 5'd20;
      4'h8: r = 5'd4;   4'h9: r = 5'd11;  4'ha: r = 5'd16;  4'hb: r = 5'd23;
      4'hc: r = 5'd6;   4'hd: r = 5'd10;  4'he: r = 5'd15;  4'hf: r = 5'd21;
      default: r = 5'd0;
    endcase
    return r;
  endfunction

  // Message word picked by a round
  function automatic logic [3:0] msg_index(input logic [5:0] rc);
    logic [7:0] r8;
    logic [7:0] g;
    r8 = {2'b00, rc};
    case (rc[5:4])
      2'd0:    g = r8;
      2'd1:    g = 8'(r8 * 8'd5) + 8'd1;
      2'd2:    g = 8'(r8 * 8'd3) + 8'd5;
      default: g = 8'(r8 * 8'd7);
    endcase
    return g[3:0];
  endfunction

endpackage

`default_nettype wire

// ===== rtl/md5_byte_if.sv =====
// Input channel of the MD5 hash unit: one message byte per beat.
// Stands alone; used by the top level.
`default_nettype none

interface md5_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       byte_present;
  logic       last_item;

  modport source (output valid, output data_byte, output byte_present,
                  output last_item, input ready);
  modport sink (input valid, input data_byte, input byte_present,
                input last_item, output ready);
endinterface

`default_nettype wire

// ===== rtl/md5_digest_if.sv =====
// Output channel of the MD5 hash unit: one digest word per beat.
// Stands alone; used by the top level.
`default_nettype none

interface md5_digest_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [1:0]  word_index;
  logic        last_word;

  modport source (output valid, output digest_word, output word_index,
                  output last_word, input ready);
  modport sink (input valid, input digest_word, input word_index,
                input last_word, output ready);
endinterface

`default_nettype wire

// ===== rtl/md5_ctrl.sv =====
// Sequencer of the MD5 hash unit: byte intake, padding, rounds, digest hand-off.
// Depends on md5_pkg for the command and status structs.
`default_nettype none

module md5_ctrl (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  input  wire logic               in_present_i,
  input  wire logic               in_last_i,
  output logic                    in_ready_o,
  input  wire md5_pkg::md5_status_t status_i,
  output md5_pkg::md5_cmd_t       cmd_o
);

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_PAD    = 7'b0000010,
    S_LEN    = 7'b0000100,
    S_LOAD   = 7'b0001000,
    S_ROUND  = 7'b0010000,
    S_ADD    = 7'b0100000,
    S_FINISH = 7'b1000000
  } state_e;

  // Where to go once a block is folded in
  typedef enum logic [1:0] {
    RET_IDLE = 2'd0,
    RET_PAD  = 2'd1,
    RET_LEN  = 2'd2,
    RET_FIN  = 2'd3
  } ret_e;

  state_e state_q, state_d;
  ret_e   ret_q, ret_d;

  assign in_ready_o = (state_q == S_IDLE);

  // Next state and commands
  always_comb begin
    state_d = state_q;
    ret_d   = ret_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          if (in_present_i && status_i.pos_last) begin
            state_d = S_LOAD;
            ret_d   = in_last_i ? RET_PAD : RET_IDLE;
          end else if (in_last_i) begin
            state_d = S_PAD;
          end
        end
      end
      S_PAD: begin
        cmd_o.pad = 1'b1;
        state_d   = S_LOAD;
        ret_d     = status_i.pos_gt55 ? RET_LEN : RET_FIN;
      end
      S_LEN: begin
        cmd_o.len = 1'b1;
        state_d   = S_LOAD;
        ret_d     = RET_FIN;
      end
      S_LOAD: begin
        cmd_o.load = 1'b1;
        state_d    = S_ROUND;
      end
      S_ROUND: begin
        cmd_o.step = 1'b1;
        if (status_i.round_last) begin
          state_d = S_ADD;
        end
      end
      S_ADD: begin
        cmd_o.add = 1'b1;
        case (ret_q)
          RET_IDLE: state_d = S_IDLE;
          RET_PAD:  state_d = S_PAD;
          RET_LEN:  state_d = S_LEN;
          RET_FIN:  state_d = S_FINISH;
          default:  state_d = S_IDLE;
        endcase
      end
      S_FINISH: begin
        // hold until the previous digest has drained
        if (!status_i.out_busy) begin
          cmd_o.finish = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ret_q   <= RET_IDLE;
    end else begin
      state_q <= state_d;
      ret_q   <= ret_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/md5_dp.sv =====
// Datapath of the MD5 hash unit: message words, round unit, chaining state,
// bit length and the digest output buffer. Depends on md5_pkg.
`default_nettype none

module md5_dp (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire md5_pkg::md5_cmd_t    cmd_i,
  output md5_pkg::md5_status_t      status_o,
  input  wire logic [7:0]           data_byte_i,
  input  wire logic                 byte_present_i,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output logic [31:0]               digest_word_o,
  output logic [1:0]                word_index_o,
  output logic                      last_word_o
);

  logic [31:0] msg_q   [16];
  logic [31:0] chain_q [4];
  logic [31:0] rw_q    [4];
  logic [31:0] out_q   [4];
  logic [63:0] bit_len_q;
  logic [5:0]  pos_q;
  logic [5:0]  rc_q;
  logic [1:0]  out_cnt_q;
  logic        out_valid_q;

  logic        wr_byte;
  logic [7:0]  wr_data;
  logic [3:0]  pos_word;
  logic [1:0]  pos_lane;

  logic [31:0] f_val;
  logic [31:0] t_val;
  logic [63:0] rot_wide;
  logic [31:0] b_new;

  assign pos_word = pos_q[5:2];
  assign pos_lane = pos_q[1:0];
  assign wr_byte  = (cmd_i.accept && byte_present_i) || cmd_i.pad;
  assign wr_data  = cmd_i.pad ? md5_pkg::PAD_BYTE : data_byte_i;

  // Status back to the sequencer
  assign status_o.pos_last   = (pos_q == 6'd63);
  assign status_o.pos_gt55   = (pos_q > md5_pkg::LEN_LIMIT_POS);
  assign status_o.round_last = (rc_q == 6'd63);
  assign status_o.out_busy   = out_valid_q;

  // One round: mixing function, four-way sum, rotate, add
  always_comb begin
    case (rc_q[5:4])
      2'd0:    f_val = (rw_q[1] & rw_q[2]) | (~rw_q[1] & rw_q[3]);
      2'd1:    f_val = (rw_q[3] & rw_q[1]) | (~rw_q[3] & rw_q[2]);
      2'd2:    f_val = rw_q[1] ^ rw_q[2] ^ rw_q[3];
      default: f_val = rw_q[2] ^ (rw_q[1] | ~rw_q[3]);
    endcase
    t_val    = f_val + rw_q[0] + md5_pkg::round_const(rc_q)
               + msg_q[md5_pkg::msg_index(rc_q)];
    rot_wide = {t_val, t_val} << md5_pkg::rot_amount(rc_q);
    b_new    = rw_q[1] + rot_wide[63:32];
  end

  // Message words: byte packing, padding and length
  always_ff @(posedge clk_i) begin
    for (int w = 0; w < 16; w++) begin
      if (cmd_i.len) begin
        if (w == 14) begin
          msg_q[w] <= bit_len_q[31:0];
        end else if (w == 15) begin
          msg_q[w] <= bit_len_q[63:32];
        end else begin
          msg_q[w] <= '0;
        end
      end else if (wr_byte && (4'(w) == pos_word)) begin
        if (pos_lane == 2'd0) begin
          msg_q[w] <= {24'h0, wr_data};
        end else begin
          msg_q[w][{pos_lane, 3'b000} +: 8] <= wr_data;
        end
      end else if (cmd_i.pad && (4'(w) > pos_word)) begin
        if (!status_o.pos_gt55 && (w == 14)) begin
          msg_q[w] <= bit_len_q[31:0];
        end else if (!status_o.pos_gt55 && (w == 15)) begin
          msg_q[w] <= bit_len_q[63:32];
        end else begin
          msg_q[w] <= '0;
        end
      end
    end
  end

  // Digest words held for the output side
  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      for (int k = 0; k < 4; k++) begin
        out_q[k] <= chain_q[k];
      end
    end
  end

  // Chaining state, working words, counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < 4; k++) begin
        chain_q[k] <= md5_pkg::MD5_IV[k];
        rw_q[k]    <= '0;
      end
      bit_len_q   <= '0;
      pos_q       <= '0;
      rc_q        <= '0;
      out_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.accept && byte_present_i) begin
        bit_len_q <= bit_len_q + md5_pkg::BITS_PER_BYTE;
        pos_q     <= pos_q + 6'd1;
      end
      if (cmd_i.load) begin
        for (int k = 0; k < 4; k++) begin
          rw_q[k] <= chain_q[k];
        end
        rc_q <= '0;
      end
      if (cmd_i.step) begin
        rw_q[0] <= rw_q[3];
        rw_q[1] <= b_new;
        rw_q[2] <= rw_q[1];
        rw_q[3] <= rw_q[2];
        rc_q    <= rc_q + 6'd1;
      end
      if (cmd_i.add) begin
        for (int k = 0; k < 4; k++) begin
          chain_q[k] <= chain_q[k] + rw_q[k];
        end
      end
      // restart for the next message once the digest is taken over
      if (cmd_i.finish) begin
        for (int k = 0; k < 4; k++) begin
          chain_q[k] <= md5_pkg::MD5_IV[k];
          rw_q[k]    <= '0;
        end
        bit_len_q   <= '0;
        pos_q       <= '0;
        rc_q        <= '0;
        out_cnt_q   <= '0;
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        // advance to the next digest word, drop the buffer after the fourth
        out_cnt_q <= out_cnt_q + 2'd1;
        if (out_cnt_q == 2'd3) begin
          out_valid_q <= 1'b0;
        end
      end
    end
  end

  assign out_valid_o   = out_valid_q;
  assign digest_word_o = out_q[out_cnt_q];
  assign word_index_o  = out_cnt_q;
  assign last_word_o   = (out_cnt_q == 2'd3);

endmodule

`default_nettype wire

// ===== rtl/md5_hash_unit.sv =====
// Top level of the MD5 hash unit: sequencer plus datapath.
// Depends on md5_pkg, md5_byte_if, md5_digest_if, md5_ctrl and md5_dp.
`default_nettype none

// A message enters one byte per beat on byte_i and is accepted while the
// unit is taking bytes. Every 64th byte starts the compression of a full
// block: the working words are loaded, the rounds run on the shared round
// unit (one round per cycle) and the result is folded into the chaining
// state; no bytes are taken meanwhile. A beat with last_item set pads the
// message and compresses one more block or, when fewer than nine bytes are
// left in the block, two, with the length written before the second; then
// the digest is handed to a four-word output buffer. The four words leave
// on digest_o, word 0 first, while the next message is already being taken;
// a following digest waits only if that buffer has not yet drained. A beat
// with byte_present clear and last_item clear is accepted and ignored.
module md5_hash_unit (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  md5_byte_if.sink         byte_i,
  md5_digest_if.source     digest_o
);

  md5_pkg::md5_cmd_t    cmd;
  md5_pkg::md5_status_t status;

  md5_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (byte_i.valid),
    .in_present_i (byte_i.byte_present),
    .in_last_i    (byte_i.last_item),
    .in_ready_o   (byte_i.ready),
    .status_i     (status),
    .cmd_o        (cmd)
  );

  md5_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .data_byte_i    (byte_i.data_byte),
    .byte_present_i (byte_i.byte_present),
    .out_valid_o    (digest_o.valid),
    .out_ready_i    (digest_o.ready),
    .digest_word_o  (digest_o.digest_word),
    .word_index_o   (digest_o.word_index),
    .last_word_o    (digest_o.last_word)
  );

endmodule

`default_nettype wire
